// File: design/gs_pkg.sv
package gs_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int DATA_WIDTH   = 32;

    // Bits of each value actually held and compared
    localparam int STORE_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int BEAT_W  = 32;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_PLACE = 6'b000100,
        ST_ERD   = 6'b001000,
        ST_ELD   = 6'b010000,
        ST_EOUT  = 6'b100000
    } state_t;

endpackage

// File: design/gs_ram.sv
module gs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/gnome_sorter.sv
// Channel   Dir  Signals                                  Contents
// s_axis    in   tvalid tready tdata[31:0] tlast          value, last
// m_axis    out  tvalid tready tdata[31:0] tlast tuser    value_res, last_res, dropped
//
// Each value is inserted into its sorted place as it arrives, so the store is
// always ordered. A beat into an empty store is written at once; else the tail
// is read, then each held element greater than it moves up one place (one read
// and one write of the single store RAM per cycle) and the value is written into
// the hole. After the last beat each result goes through a registered RAM read,
// then the output register, and is held while m_axis_tready is low; input is
// held off until the final result is taken. Reset clears the state, count,
// last and drop flags; store entries are read only once written in this run.
module gnome_sorter
    import gs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BEAT_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BEAT_W-1:0] m_axis_tdata,   // [31:0] value_res
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] dropped
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                last_pend_reg, last_pend_next;
    logic [STORE_W-1:0]  key_reg, key_next;
    logic [ADDR_W-1:0]   hole_reg, hole_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [BEAT_W-1:0]   out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [STORE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    logic [STORE_W-1:0]  in_value;
    logic [CNT_W-1:0]    cnt_dec;

    assign in_value = s_axis_tdata[STORE_W-1:0];
    assign cnt_dec  = count_reg - CNT_W'(1);

    gs_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_pend_next = last_pend_reg;
        key_next       = key_reg;
        hole_next      = hole_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = hole_reg;
        ram_wdata      = key_reg;
        ram_raddr      = k_reg;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    k_next = '0;
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        key_next       = in_value;
                        last_pend_next = s_axis_tlast;
                        count_next     = count_reg + CNT_W'(1);
                        hole_next      = count_reg[ADDR_W-1:0];
                        if (count_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = in_value;
                            state_next = s_axis_tlast ? ST_ERD : ST_IDLE;
                        end
                        else
                        begin
                            // fetch the current tail to compare against
                            ram_raddr  = cnt_dec[ADDR_W-1:0];
                            state_next = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (s_axis_tlast)
                        begin
                            state_next = ST_ERD;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = hole_reg;
                if ($signed(ram_rdata) > $signed(key_reg))
                begin
                    // move the larger neighbor up, walk the hole left
                    ram_wdata = ram_rdata;
                    if (hole_reg == ADDR_W'(1))
                    begin
                        hole_next  = '0;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        hole_next = hole_reg - ADDR_W'(1);
                        ram_raddr = hole_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    ram_wdata  = key_reg;
                    state_next = last_pend_reg ? ST_ERD : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hole_reg;
                ram_wdata  = key_reg;
                state_next = last_pend_reg ? ST_ERD : ST_IDLE;
            end

            ST_ERD:
            begin
                ram_raddr  = k_reg;
                state_next = ST_ELD;
            end

            ST_ELD:
            begin
                out_data_next = BEAT_W'($signed(ram_rdata));
                out_last_next = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
                state_next    = ST_EOUT;
            end

            ST_EOUT:
            begin
                if (m_axis_tready)
                begin
                    if (out_last_reg)
                    begin
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        last_pend_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        ram_raddr  = k_reg + ADDR_W'(1);
                        state_next = ST_ELD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hole_reg     <= hole_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = (state_reg == ST_EOUT);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = ovf_reg;

endmodule
